// ===== rtl/scht_pkg.sv =====
// shared types and constants for the string count hash table
// used by scht_hash, scht_slots and string_count_hash_table_top
`default_nettype none
package scht_pkg;

    localparam int TABLE_SLOTS   = 4096;
    localparam int SLOT_W        = $clog2(TABLE_SLOTS);
    localparam int MAX_KEY_BYTES = 64;
    localparam int KLEN_W        = 7;
    localparam int POS_STRIDE    = 'h40;
    localparam int BYTE_VALUES   = 'h100;
    localparam int WORD_COUNT    = POS_STRIDE * BYTE_VALUES;
    localparam int HW_AW         = $clog2(WORD_COUNT);
    localparam int POS_W         = $clog2(POS_STRIDE);
    localparam int KEY_WORDS     = MAX_KEY_BYTES / 8;
    localparam int KW_W          = $clog2(KEY_WORDS);
    localparam int KEY_AW        = SLOT_W + KW_W;
    localparam int PH_DEPTH      = MAX_KEY_BYTES / 2;
    localparam int PH_W          = $clog2(PH_DEPTH);
    localparam logic [31:0] COUNT_MAX = 32'h7fff_ffff;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_COUNT  = 3'd3,
        CMD_PREFIX = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADLEN   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PR_EMPTY = 2'd0,
        PR_MATCH = 2'd1,
        PR_FULL  = 2'd2
    } t_probe;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HWAIT,
        S_START,
        S_PRD,
        S_PCHK,
        S_KCMP,
        S_KWR,
        S_PSTART,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              used;
        logic [KLEN_W-1:0] klen;
        logic [31:0]       count;
        logic [KLEN_W-1:0] closest;
    } t_slot_rec;

endpackage
`default_nettype wire

// ===== rtl/scht_hash.sv =====
// key builder: tabulation word memory, running hash, key buffer, prefix hashes
// depends on scht_pkg
`default_nettype none
module scht_hash (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic [scht_pkg::HW_AW-1:0]  i_load_addr,
    input  wire logic [31:0]                 i_load_data,
    input  wire logic                        i_byte_en,
    input  wire logic [7:0]                  i_byte,
    input  wire logic                        i_clear,
    input  wire logic [scht_pkg::KW_W-1:0]   i_kw_sel,
    input  wire logic [scht_pkg::PH_W-1:0]   i_ph_sel,
    output logic [scht_pkg::KLEN_W-1:0]      o_key_len,
    output logic [31:0]                      o_hash,
    output logic [63:0]                      o_kword,
    output logic [31:0]                      o_phash
);
    import scht_pkg::*;

    logic [31:0]       r_mem [WORD_COUNT];
    logic [31:0]       r_rdata;
    logic [7:0]        r_pbyte;
    logic [63:0]       r_kbuf [KEY_WORDS];
    logic [31:0]       r_ph [PH_DEPTH];
    logic [KLEN_W-1:0] r_len;
    logic [31:0]       r_hash;
    logic              r_pend;
    logic              rd;
    logic [KLEN_W-1:0] nlen;
    logic [31:0]       nhash;

    assign rd    = i_byte_en && (r_len < KLEN_W'(MAX_KEY_BYTES));
    assign nlen  = r_len + KLEN_W'(1);
    assign nhash = r_hash ^ r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mem[i_load_addr] <= i_load_data;
        end
        if (rd) begin
            r_rdata <= r_mem[{i_byte, r_len[POS_W-1:0]}];
            r_pbyte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= '0;
            r_pend <= 1'b0;
        end else if (i_clear) begin
            r_len  <= '0;
            r_hash <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= rd;
            if (i_byte_en && !rd) begin
                r_len <= KLEN_W'(MAX_KEY_BYTES + 1);
            end
            if (r_pend) begin
                r_hash <= nhash;
                r_len  <= nlen;
            end
        end
    end

    // buffer every byte, and the hash after every even length below 64
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_kbuf[r_len[POS_W-1:3]][{r_len[2:0], 3'b000} +: 8] <= r_pbyte;
            if (!nlen[0] && !nlen[KLEN_W-1]) begin
                r_ph[nlen[PH_W:1]] <= nhash;
            end
        end
    end

    assign o_key_len = r_len;
    assign o_hash    = r_hash;
    assign o_kword   = r_kbuf[i_kw_sel];
    assign o_phash   = r_ph[i_ph_sel];

endmodule
`default_nettype wire

// ===== rtl/scht_slots.sv =====
// slot store: record memory with clearing pass after reset, key word memory
// depends on scht_pkg
`default_nettype none
module scht_slots (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    output logic                              o_ready,
    input  wire logic                         i_rec_rd,
    input  wire logic [scht_pkg::SLOT_W-1:0]  i_rec_addr,
    output scht_pkg::t_slot_rec               o_rec,
    input  wire logic                         i_rec_wr,
    input  scht_pkg::t_slot_rec               i_rec_wdata,
    input  wire logic                         i_key_rd,
    input  wire logic [scht_pkg::KEY_AW-1:0]  i_key_addr,
    output logic [63:0]                       o_key,
    input  wire logic                         i_key_wr,
    input  wire logic [63:0]                  i_key_wdata
);
    import scht_pkg::*;

    t_slot_rec         r_rec_mem [TABLE_SLOTS];
    logic [63:0]       r_key_mem [TABLE_SLOTS * KEY_WORDS];
    logic              r_clr;
    logic [SLOT_W-1:0] r_cidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_cidx <= '0;
        end else if (r_clr) begin
            r_cidx <= r_cidx + SLOT_W'(1);
            if (r_cidx == SLOT_W'(TABLE_SLOTS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_rec_mem[r_cidx] <= '0;
        end else if (i_rec_wr) begin
            r_rec_mem[i_rec_addr] <= i_rec_wdata;
        end
        if (i_rec_rd) begin
            o_rec <= r_rec_mem[i_rec_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key_wr) begin
            r_key_mem[i_key_addr] <= i_key_wdata;
        end
        if (i_key_rd) begin
            o_key <= r_key_mem[i_key_addr];
        end
    end

    assign o_ready = !r_clr;

endmodule
`default_nettype wire

// ===== rtl/string_count_hash_table_top.sv =====
// string count hash table, top level with the probe sequencer
// depends on scht_pkg, scht_hash, scht_slots
//
// A key arrives one byte per word; each byte takes a tabulation word read,
// then that word is folded into the running hash. On the final byte the
// sequencer walks the slot table linearly from hash mod 4096: each slot
// visited takes a record memory read and check, and on lookup, count and
// prefix walks a compare per 8-byte key word when the stored length
// matches; a new entry also writes its key words. Prefix insert then repeats
// the walk for each shorter prefix of the key's length parity, of 4 bytes or
// more. After reset a clearing pass sweeps all 4096 slots of the record
// memory and no word is taken until it finishes. A finished result sits in
// an output register, so the next key can start while it waits to be taken.
`default_nettype none
module string_count_hash_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_last_byte,
    input  wire logic signed [31:0] i_insert_value,
    input  wire logic [13:0] i_word_address,
    input  wire logic [31:0] i_word_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic signed [31:0] o_entry_value,
    output logic [6:0]       o_closest_word_length,
    output logic [11:0]      o_slot_index
);
    import scht_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic              r_last, n_last;
    logic [31:0]       r_val, n_val;
    logic [KLEN_W-1:0] r_len, n_len;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_n, n_n;
    logic              r_want, n_want;
    logic [KLEN_W-1:0] r_plen, n_plen;
    logic              r_pmode, n_pmode;
    logic [KW_W-1:0]   r_w, n_w;
    t_slot_rec         r_rec, n_rec;
    logic [KLEN_W-1:0] r_i, n_i;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_status           r_res_st, n_res_st;
    logic [31:0]       r_res_val, n_res_val;
    logic [KLEN_W-1:0] r_res_cl, n_res_cl;
    logic              r_ov, n_ov;
    t_status           r_o_st, n_o_st;
    logic [31:0]       r_o_val, n_o_val;
    logic [KLEN_W-1:0] r_o_cl, n_o_cl;
    logic [SLOT_W-1:0] r_o_idx, n_o_idx;

    logic              h_load, h_byte_en, h_clear;
    logic [KLEN_W-1:0] h_key_len;
    logic [31:0]       h_hash, h_phash;
    logic [63:0]       h_kword;
    logic              s_ready, s_rec_rd, s_rec_wr, s_key_rd, s_key_wr;
    logic [SLOT_W-1:0] s_rec_addr;
    t_slot_rec         s_rec, s_rec_wdata;
    logic [KEY_AW-1:0] s_key_addr;
    logic [63:0]       s_key;

    logic              accept, adv, pe, kmatch;
    t_probe            pk;
    logic [KLEN_W-1:0] plen_m1;
    logic [KW_W-1:0]   lw;
    logic [31:0]       cnt_inc;

    scht_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (h_load),
        .i_load_addr (i_word_address),
        .i_load_data (i_word_data),
        .i_byte_en   (h_byte_en),
        .i_byte      (i_key_byte),
        .i_clear     (h_clear),
        .i_kw_sel    (r_w),
        .i_ph_sel    (r_i[PH_W:1]),
        .o_key_len   (h_key_len),
        .o_hash      (h_hash),
        .o_kword     (h_kword),
        .o_phash     (h_phash)
    );

    scht_slots u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_ready     (s_ready),
        .i_rec_rd    (s_rec_rd),
        .i_rec_addr  (s_rec_addr),
        .o_rec       (s_rec),
        .i_rec_wr    (s_rec_wr),
        .i_rec_wdata (s_rec_wdata),
        .i_key_rd    (s_key_rd),
        .i_key_addr  (s_key_addr),
        .o_key       (s_key),
        .i_key_wr    (s_key_wr),
        .i_key_wdata (h_kword)
    );

    assign plen_m1 = r_plen - KLEN_W'(1);
    assign lw      = plen_m1[POS_W-1:3];
    assign cnt_inc = (r_rec.count != COUNT_MAX) ? r_rec.count + 32'd1 : r_rec.count;

    // compare only the bytes below the probed length
    always_comb begin
        kmatch = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if ({1'b0, r_w, 3'(b)} < r_plen && h_kword[b*8 +: 8] != s_key[b*8 +: 8]) begin
                kmatch = 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_last    = r_last;
        n_val     = r_val;
        n_len     = r_len;
        n_idx     = r_idx;
        n_n       = r_n;
        n_want    = r_want;
        n_plen    = r_plen;
        n_pmode   = r_pmode;
        n_w       = r_w;
        n_rec     = r_rec;
        n_i       = r_i;
        n_slot    = r_slot;
        n_res_st  = r_res_st;
        n_res_val = r_res_val;
        n_res_cl  = r_res_cl;
        n_ov      = r_ov && i_out_stall;
        n_o_st    = r_o_st;
        n_o_val   = r_o_val;
        n_o_cl    = r_o_cl;
        n_o_idx   = r_o_idx;
        h_load    = 1'b0;
        h_byte_en = 1'b0;
        h_clear   = 1'b0;
        s_rec_rd  = 1'b0;
        s_rec_wr  = 1'b0;
        s_rec_addr  = r_idx;
        s_rec_wdata = r_rec;
        s_key_rd  = 1'b0;
        s_key_wr  = 1'b0;
        s_key_addr = {r_idx, r_w};
        adv       = 1'b0;
        pe        = 1'b0;
        pk        = PR_EMPTY;
        o_in_stall = !(r_state == S_IDLE && s_ready);
        accept    = i_in_valid && !o_in_stall;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_LOAD: h_load = 1'b1;
                        CMD_LOOKUP, CMD_INSERT, CMD_COUNT, CMD_PREFIX: begin
                            h_byte_en = 1'b1;
                            n_cmd     = t_cmd'(i_command);
                            n_last    = i_last_byte;
                            n_val     = i_insert_value;
                            n_state   = S_HWAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_HWAIT: n_state = r_last ? S_START : S_IDLE;
            S_START: begin
                h_clear = 1'b1;
                n_len   = h_key_len;
                if (h_key_len > KLEN_W'(MAX_KEY_BYTES)) begin
                    n_res_st  = ST_BADLEN;
                    n_res_val = '0;
                    n_res_cl  = '0;
                    n_slot    = '0;
                    n_state   = S_FIN;
                end else begin
                    n_pmode = 1'b0;
                    n_idx   = h_hash[SLOT_W-1:0];
                    n_n     = '0;
                    n_plen  = h_key_len;
                    n_want  = (r_cmd == CMD_LOOKUP) || (r_cmd == CMD_COUNT);
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                s_rec_rd = 1'b1;
                n_state  = S_PCHK;
            end
            S_PCHK: begin
                n_rec = s_rec;
                if (!s_rec.used) begin
                    pe = 1'b1;
                    pk = PR_EMPTY;
                end else if (r_want && s_rec.klen == r_plen) begin
                    s_key_rd   = 1'b1;
                    s_key_addr = {r_idx, KW_W'(0)};
                    n_w        = '0;
                    n_state    = S_KCMP;
                end else begin
                    adv = 1'b1;
                end
            end
            S_KCMP: begin
                if (!kmatch) begin
                    adv = 1'b1;
                end else if (r_w == lw) begin
                    pe = 1'b1;
                    pk = PR_MATCH;
                end else begin
                    s_key_rd   = 1'b1;
                    s_key_addr = {r_idx, r_w + KW_W'(1)};
                    n_w        = r_w + KW_W'(1);
                end
            end
            S_KWR: begin
                s_key_wr   = 1'b1;
                s_key_addr = {r_slot, r_w};
                if (r_w == lw) begin
                    if (r_cmd == CMD_PREFIX && r_len >= KLEN_W'(6)) begin
                        n_i     = r_len - KLEN_W'(2);
                        n_state = S_PSTART;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_w = r_w + KW_W'(1);
                end
            end
            S_PSTART: begin
                n_idx   = h_phash[SLOT_W-1:0];
                n_n     = '0;
                n_plen  = r_i;
                n_want  = 1'b1;
                n_pmode = 1'b1;
                n_state = S_PRD;
            end
            S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_o_st  = r_res_st;
                    n_o_val = r_res_val;
                    n_o_cl  = r_res_cl;
                    n_o_idx = r_slot;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next slot with wraparound
        if (adv) begin
            if (r_n == SLOT_W'(TABLE_SLOTS - 1)) begin
                pe = 1'b1;
                pk = PR_FULL;
            end else begin
                n_idx   = r_idx + SLOT_W'(1);
                n_n     = r_n + SLOT_W'(1);
                n_state = S_PRD;
            end
        end

        if (pe) begin
            if (r_pmode) begin
                if (pk == PR_MATCH &&
                    (r_rec.closest == '0 || r_len < r_rec.closest)) begin
                    s_rec_wr    = 1'b1;
                    s_rec_wdata = r_rec;
                    s_rec_wdata.closest = r_len;
                end
                if (r_i >= KLEN_W'(6)) begin
                    n_i     = r_i - KLEN_W'(2);
                    n_state = S_PSTART;
                end else begin
                    n_state = S_FIN;
                end
            end else begin
                n_res_val = '0;
                n_res_cl  = '0;
                n_slot    = '0;
                n_state   = S_FIN;
                if (r_cmd == CMD_LOOKUP) begin
                    if (pk == PR_MATCH) begin
                        n_res_st  = ST_OK;
                        n_res_val = r_rec.count;
                        n_res_cl  = r_rec.closest;
                        n_slot    = r_idx;
                    end else begin
                        n_res_st = ST_NOTFOUND;
                    end
                end else if (pk == PR_FULL) begin
                    n_res_st = ST_FULL;
                end else if (pk == PR_MATCH) begin
                    // count hit
                    s_rec_wr    = 1'b1;
                    s_rec_wdata = r_rec;
                    s_rec_wdata.count = cnt_inc;
                    n_res_st  = ST_OK;
                    n_res_val = cnt_inc;
                    n_res_cl  = r_rec.closest;
                    n_slot    = r_idx;
                end else begin
                    s_rec_wr            = 1'b1;
                    s_rec_wdata.used    = 1'b1;
                    s_rec_wdata.klen    = r_len;
                    s_rec_wdata.closest = '0;
                    case (r_cmd)
                        CMD_INSERT: s_rec_wdata.count = r_val;
                        CMD_COUNT:  s_rec_wdata.count = 32'd1;
                        default:    s_rec_wdata.count = '0;
                    endcase
                    n_res_st  = ST_OK;
                    n_res_val = s_rec_wdata.count;
                    n_slot    = r_idx;
                    n_w       = '0;
                    n_state   = S_KWR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_last    <= n_last;
        r_val     <= n_val;
        r_len     <= n_len;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_want    <= n_want;
        r_plen    <= n_plen;
        r_pmode   <= n_pmode;
        r_w       <= n_w;
        r_rec     <= n_rec;
        r_i       <= n_i;
        r_slot    <= n_slot;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
        r_res_cl  <= n_res_cl;
        r_o_st    <= n_o_st;
        r_o_val   <= n_o_val;
        r_o_cl    <= n_o_cl;
        r_o_idx   <= n_o_idx;
    end

    assign o_out_valid           = r_ov;
    assign o_status              = r_o_st;
    assign o_entry_value         = r_o_val;
    assign o_closest_word_length = r_o_cl;
    assign o_slot_index          = r_o_idx;

endmodule
`default_nettype wire
